// File: sv/ped_pkg.sv
package ped_pkg;

    // Register field and payload widths
    localparam int DIM_W   = 13;
    localparam int PAD_W   = 6;
    localparam int PIX_W   = 8;
    localparam int COORD_W = 14;

    // APB port geometry
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Job queue between classifier and rectangle generator
    localparam int Q_DEPTH = 4;

    // Rectangles per edge pixel, at most
    localparam int N_RECT  = 8;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_PAD    = 2'd2
    } t_reg_idx;

    // Emission order of the fill rectangles; the value is the bit in the job mask
    typedef enum logic [2:0] {
        RK_TL    = 3'd0,
        RK_TOP   = 3'd1,
        RK_TR    = 3'd2,
        RK_LEFT  = 3'd3,
        RK_RIGHT = 3'd4,
        RK_BL    = 3'd5,
        RK_BOT   = 3'd6,
        RK_BR    = 3'd7
    } t_rect_kind;

    typedef logic [N_RECT-1:0] t_rect_mask;

    // Clamped plane geometry as seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [PAD_W-1:0] pad;
    } t_geom;

endpackage

// File: sv/ped_if.sv
interface ped_pix_if import ped_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface ped_rect_if import ped_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] rect_x;
    logic signed [COORD_W-1:0] rect_y;
    logic        [PAD_W-1:0]   rect_width;
    logic        [PAD_W-1:0]   rect_height;
    logic        [PIX_W-1:0]   fill_value;
    logic                      last_of_run;

    modport source (output valid, output rect_x, output rect_y, output rect_width,
                    output rect_height, output fill_value, output last_of_run,
                    input ready);
    modport sink   (input valid, input rect_x, input rect_y, input rect_width,
                    input rect_height, input fill_value, input last_of_run,
                    output ready);
endinterface

// File: sv/picture_edge_padding.sv
// Channel   Dir  Beat                                       Accept
// i_pix     in   one pixel, raster order                    valid & ready
// o_rect    out  one fill rectangle with its pixel value    valid & ready
// apb       in   register write / read, pready always high  psel & penable & pwrite
//
// A pixel is taken every cycle while the four-entry job queue has room; interior
// pixels leave nothing behind, edge pixels queue one job.
// The rectangle generator issues one rectangle per cycle while o_rect is not stalled,
// and an edge pixel yields as many rectangles as its mask has bits (1 to 8) in the back.
// Sustained input rate is one pixel per cycle inside a row; plane edges stall the
// input once the queue fills. Reset is synchronous and empties queue and output.
module picture_edge_padding import ped_pkg::*; #(
    parameter int MAX_DIM = 4096,
    parameter int MAX_PAD = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ped_pix_if.sink           i_pix,
    ped_rect_if.source        o_rect,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int ENTRY_W = N_RECT + 2 * CNT_W + PIX_W;

    t_geom            geom;
    logic             restart;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    t_rect_mask       f_mask;
    logic [CNT_W-1:0] f_col;
    logic [CNT_W-1:0] f_row;
    logic [PIX_W-1:0] f_value;
    t_rect_mask       b_mask;
    logic [CNT_W-1:0] b_col;
    logic [CNT_W-1:0] b_row;
    logic [PIX_W-1:0] b_value;

    ped_regs #(
        .MAX_DIM (MAX_DIM),
        .MAX_PAD (MAX_PAD)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_geom    (geom),
        .o_restart (restart)
    );

    ped_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_restart (restart),
        .i_pix     (i_pix),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_mask    (f_mask),
        .o_col     (f_col),
        .o_row     (f_row),
        .o_value   (f_value)
    );

    ped_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_mask, f_col, f_row, f_value}),
        .i_pop   (pop),
        .o_data  ({b_mask, b_col, b_row, b_value}),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ped_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_q_empty (q_empty),
        .i_mask    (b_mask),
        .i_col     (b_col),
        .i_row     (b_row),
        .i_value   (b_value),
        .o_pop     (pop),
        .o_rect    (o_rect)
    );

endmodule

// File: sv/ped_regs.sv
module ped_regs import ped_pkg::*; #(
    parameter int MAX_DIM = 4096,
    parameter int MAX_PAD = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_geom             o_geom,
    output logic              o_restart
);

    localparam int PAD_CAP = (MAX_PAD > 63) ? 63 : MAX_PAD;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [PAD_W-1:0] r_pad;
    logic             wr;
    t_reg_idx         idx;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

    function automatic logic [PAD_W-1:0] clamp_pad(input logic [PAD_W-1:0] v);
        logic [PAD_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = PAD_W'(1);
        end else if (int'(v) > PAD_CAP) begin
            res = PAD_W'(PAD_CAP);
        end
        return res;
    endfunction

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(16);
            r_height <= DIM_W'(16);
            r_pad    <= PAD_W'(32);
        end else if (wr) begin
            case (idx)
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_PAD:    r_pad    <= pwdata[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Geometry change opens a new plane
    assign o_restart = wr & ((idx == REG_WIDTH) | (idx == REG_HEIGHT));

    // Read back raw register contents
    always_comb begin
        case (idx)
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            REG_PAD:    prdata = DATA_W'(r_pad);
            default:    prdata = '0;
        endcase
    end

    assign o_geom.width  = clamp_dim(r_width);
    assign o_geom.height = clamp_dim(r_height);
    assign o_geom.pad    = clamp_pad(r_pad);

endmodule

// File: sv/ped_front.sv
module ped_front import ped_pkg::*; #(
    parameter int CNT_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_geom            i_geom,
    input  logic             i_restart,
    ped_pix_if.sink          i_pix,
    input  logic             i_q_full,
    output logic             o_push,
    output t_rect_mask       o_mask,
    output logic [CNT_W-1:0] o_col,
    output logic [CNT_W-1:0] o_row,
    output logic [PIX_W-1:0] o_value
);

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic             accept;
    logic             top;
    logic             bottom;
    logic             left;
    logic             right;

    assign i_pix.ready = ~i_q_full;
    assign accept      = i_pix.valid & ~i_q_full;

    // Classify the current position
    assign top    = (r_row == '0);
    assign left   = (r_col == '0);
    assign right  = (DIM_W'(r_col) == i_geom.width - DIM_W'(1));
    assign bottom = (DIM_W'(r_row) == i_geom.height - DIM_W'(1));

    always_comb begin
        o_mask           = '0;
        o_mask[RK_TL]    = top & left;
        o_mask[RK_TOP]   = top;
        o_mask[RK_TR]    = top & right;
        o_mask[RK_LEFT]  = left;
        o_mask[RK_RIGHT] = right;
        o_mask[RK_BL]    = bottom & left;
        o_mask[RK_BOT]   = bottom;
        o_mask[RK_BR]    = bottom & right;
    end

    // Drop interior pixels, queue edge pixels
    assign o_push  = accept & (o_mask != '0);
    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_value = i_pix.pixel_value;

    // Advance raster position, wrap after the last pixel
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (right) begin
            n_col = '0;
            n_row = bottom ? '0 : r_row + CNT_W'(1);
        end else begin
            n_col = r_col + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// File: sv/ped_queue.sv
module ped_queue import ped_pkg::*; #(
    parameter int ENTRY_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [ENTRY_W-1:0] i_data,
    input  logic               i_pop,
    output logic [ENTRY_W-1:0] o_data,
    output logic               o_empty,
    output logic               o_full
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [ENTRY_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

// File: sv/ped_back.sv
module ped_back import ped_pkg::*; #(
    parameter int CNT_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_geom            i_geom,
    input  logic             i_q_empty,
    input  t_rect_mask       i_mask,
    input  logic [CNT_W-1:0] i_col,
    input  logic [CNT_W-1:0] i_row,
    input  logic [PIX_W-1:0] i_value,
    output logic             o_pop,
    ped_rect_if.source       o_rect
);

    // Current job
    t_rect_mask       r_mask;
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [PIX_W-1:0] r_value;

    // Output register
    logic                      r_ovalid;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic        [PAD_W-1:0]   r_w;
    logic        [PAD_W-1:0]   r_h;
    logic        [PIX_W-1:0]   r_fill;
    logic                      r_last;

    logic                      out_free;
    logic                      emit;
    t_rect_mask                lowest;
    t_rect_mask                rest;
    t_rect_kind                kind;
    logic signed [COORD_W-1:0] neg_p;
    logic signed [COORD_W-1:0] col_x;
    logic signed [COORD_W-1:0] row_y;
    logic signed [COORD_W-1:0] wid_x;
    logic signed [COORD_W-1:0] hgt_y;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [PAD_W-1:0]   w;
    logic        [PAD_W-1:0]   h;

    assign out_free = ~r_ovalid | o_rect.ready;
    assign emit     = (r_mask != '0) & out_free;
    assign lowest   = r_mask & (~r_mask + t_rect_mask'(1));
    assign rest     = r_mask & ~lowest;

    // Pick the next rectangle in emission order
    always_comb begin
        kind = RK_TL;
        for (int i = N_RECT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                kind = t_rect_kind'(3'(i));
            end
        end
    end

    assign neg_p = COORD_W'(0) - COORD_W'(i_geom.pad);
    assign col_x = COORD_W'(r_col);
    assign row_y = COORD_W'(r_row);
    assign wid_x = COORD_W'(i_geom.width);
    assign hgt_y = COORD_W'(i_geom.height);

    // Form rectangle geometry
    always_comb begin
        x = neg_p;
        y = neg_p;
        w = i_geom.pad;
        h = i_geom.pad;
        case (kind)
            RK_TL:    begin x = neg_p; y = neg_p; end
            RK_TOP:   begin x = col_x; y = neg_p; w = PAD_W'(1); end
            RK_TR:    begin x = wid_x; y = neg_p; end
            RK_LEFT:  begin x = neg_p; y = row_y; h = PAD_W'(1); end
            RK_RIGHT: begin x = wid_x; y = row_y; h = PAD_W'(1); end
            RK_BL:    begin x = neg_p; y = hgt_y; end
            RK_BOT:   begin x = col_x; y = hgt_y; w = PAD_W'(1); end
            RK_BR:    begin x = wid_x; y = hgt_y; end
            default: ;
        endcase
    end

    // Load the next job when idle or once the current one issues its last rectangle
    assign o_pop = ~i_q_empty & ((r_mask == '0) | (emit & (rest == '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (o_pop) begin
            r_mask <= i_mask;
        end else if (emit) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_col   <= i_col;
            r_row   <= i_row;
            r_value <= i_value;
        end
    end

    // Hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (o_rect.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_x    <= x;
            r_y    <= y;
            r_w    <= w;
            r_h    <= h;
            r_fill <= r_value;
            r_last <= (rest == '0);
        end
    end

    assign o_rect.valid       = r_ovalid;
    assign o_rect.rect_x      = r_x;
    assign o_rect.rect_y      = r_y;
    assign o_rect.rect_width  = r_w;
    assign o_rect.rect_height = r_h;
    assign o_rect.fill_value  = r_fill;
    assign o_rect.last_of_run = r_last;

endmodule

// File: sv/ped_checker.sv
module ped_checker import ped_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [COORD_W-1:0] i_x,
    input logic [COORD_W-1:0] i_y,
    input logic [PAD_W-1:0]   i_w,
    input logic [PAD_W-1:0]   i_h,
    input logic [PIX_W-1:0]   i_fill,
    input logic               i_last
);

    // Stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_x) && $stable(i_y) &&
        $stable(i_w) && $stable(i_h) && $stable(i_fill) && $stable(i_last))
        else $error("rect beat changed while stalled");

    // Rectangles are single lines or square corners
    a_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_w != '0 && i_h != '0 &&
        (i_w == PAD_W'(1) || i_h == PAD_W'(1) || i_w == i_h))
        else $error("rect shape is neither a run nor a corner");

    // Left band rectangles end at column zero
    a_left_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_x[COORD_W-1] |-> (i_x + COORD_W'(i_w)) == '0)
        else $error("left band rect does not meet the picture");

    // Top band rectangles end at row zero
    a_top_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_y[COORD_W-1] |-> (i_y + COORD_W'(i_h)) == '0)
        else $error("top band rect does not meet the picture");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("rect valid after reset");

endmodule

bind picture_edge_padding ped_checker u_ped_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rect.valid),
    .i_ready (o_rect.ready),
    .i_x     (o_rect.rect_x),
    .i_y     (o_rect.rect_y),
    .i_w     (o_rect.rect_width),
    .i_h     (o_rect.rect_height),
    .i_fill  (o_rect.fill_value),
    .i_last  (o_rect.last_of_run)
);
